[hw/rtl/csd_pkg.sv]
package csd_pkg;

  // default data format: signed Q16.16
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

endpackage

[hw/rtl/csd_divider.sv]
module csd_divider #(
  parameter int W = csd_pkg::DATA_WIDTH,
  parameter int F = csd_pkg::FRAC_BITS
) (
  input  logic             clk,
  input  logic             en,
  input  logic [2*W-1:0]   num_mag,
  input  logic [2*W-1:0]   den,
  input  logic             neg,
  output logic [W-1:0]     quo,
  output logic             ovf,
  output logic             quo_neg
);

  localparam int XW = 2*W + F;
  localparam int RW = 2*W + 1;
  localparam int HW = (W + F > RW) ? W + F : RW;

  logic [XW-1:0] dividend;
  logic [HW-1:0] xhi_ext;
  logic [HW-1:0] den_ext;

  logic [RW-1:0]  rem_s [0:W];
  logic [2*W-1:0] den_s [0:W];
  logic [W-1:0]   low_s [0:W];
  logic [W-1:0]   quo_s [0:W];
  logic           ovf_s [0:W];
  logic           neg_s [0:W];

  // scaled dividend and overflow check: quotient would not fit in W bits
  assign dividend = XW'(num_mag) << F;
  assign xhi_ext  = HW'(dividend[XW-1:W]);
  assign den_ext  = HW'(den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= xhi_ext[RW-1:0];
      den_s[0] <= den;
      low_s[0] <= dividend[W-1:0];
      quo_s[0] <= '0;
      ovf_s[0] <= (xhi_ext >= den_ext);
      neg_s[0] <= neg;
    end
  end

  // one restoring step per stage, one quotient bit each
  for (genvar k = 0; k < W; k++) begin : g_step
    logic [RW-1:0] shifted;
    logic [RW-1:0] diff;
    logic          take;

    assign shifted = {rem_s[k][RW-2:0], low_s[k][W-1]};
    assign take    = (shifted >= RW'(den_s[k]));
    assign diff    = shifted - RW'(den_s[k]);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[k+1] <= take ? diff : shifted;
        den_s[k+1] <= den_s[k];
        low_s[k+1] <= low_s[k] << 1;
        quo_s[k+1] <= {quo_s[k][W-2:0], take};
        ovf_s[k+1] <= ovf_s[k];
        neg_s[k+1] <= neg_s[k];
      end
    end
  end

  assign quo     = quo_s[W];
  assign ovf     = ovf_s[W];
  assign quo_neg = neg_s[W];

endmodule

[hw/rtl/complex_spectrum_divide_unit.sv]
// path to result: stages a, b and c, the divider stages, then the output register
// throughput: one item per cycle when not stalled; the divider is a restoring
//   pipeline, one quotient bit per stage, real and imaginary lanes side by side
// a held result stalls the whole pipeline and holds in_ready low
// reset: synchronous, clears valid bits and conj_mode; data registers are not reset
module complex_spectrum_divide_unit #(
  parameter int DATA_WIDTH = csd_pkg::DATA_WIDTH,
  parameter int FRAC_BITS  = csd_pkg::FRAC_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] num_re,
  input  logic signed [DATA_WIDTH-1:0] num_im,
  input  logic signed [DATA_WIDTH-1:0] den_re,
  input  logic signed [DATA_WIDTH-1:0] den_im,
  input  logic                         real_only,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_re,
  output logic signed [DATA_WIDTH-1:0] out_im,
  output logic                         range_flag
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2*W;
  localparam int SW = 2*W + 1;
  localparam logic [PW-1:0] EPS = PW'(1) << FRAC_BITS;

  logic conj_mode;
  logic en;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      conj_mode <= 1'b0;
    end else if (cfg_we) begin
      conj_mode <= cfg_data;
    end
  end

  // whole pipeline advances unless a result is held
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage a: products
  logic                  va;
  logic signed [PW-1:0]  a_rr, a_ii, a_ir, a_ri, a_bb_r, a_bb_i;
  logic signed [W-1:0]   a_ar, a_br;
  logic                  a_ro;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rr   <= num_re * den_re;
      a_ii   <= num_im * den_im;
      a_ir   <= num_im * den_re;
      a_ri   <= num_re * den_im;
      a_bb_r <= den_re * den_re;
      a_bb_i <= den_im * den_im;
      a_ar   <= num_re;
      a_br   <= den_re;
      a_ro   <= real_only;
    end
  end

  // stage b: numerators and divisor
  logic                 vb;
  logic [SW-1:0]        b_nre, b_nim;
  logic [PW-1:0]        b_den;
  logic                 b_den_neg;
  logic                 b_ro;
  logic [SW-1:0]        rr_x, ii_x, ir_x, ri_x;
  logic [W:0]           bsum;
  logic [W:0]           bmag;

  assign rr_x = {a_rr[PW-1], a_rr};
  assign ii_x = {a_ii[PW-1], a_ii};
  assign ir_x = {a_ir[PW-1], a_ir};
  assign ri_x = {a_ri[PW-1], a_ri};
  assign bsum = {a_br[W-1], a_br} + (W+1)'(1);
  assign bmag = bsum[W] ? (~bsum + (W+1)'(1)) : bsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_ro <= a_ro;
      if (a_ro) begin
        b_nre     <= {{(SW-W){a_ar[W-1]}}, a_ar};
        b_nim     <= '0;
        b_den     <= PW'(bmag);
        b_den_neg <= bsum[W];
      end else begin
        b_nre     <= conj_mode ? (rr_x - ii_x) : (rr_x + ii_x);
        b_nim     <= conj_mode ? (ir_x + ri_x) : (ir_x - ri_x);
        b_den     <= a_bb_r + a_bb_i + EPS;
        b_den_neg <= 1'b0;
      end
    end
  end

  // stage c: sign and magnitude for each lane
  logic          vc;
  logic [PW-1:0] c_re_mag, c_im_mag, c_den;
  logic          c_re_neg, c_im_neg, c_ro;
  logic [SW-1:0] nre_abs, nim_abs;

  assign nre_abs = b_nre[SW-1] ? (~b_nre + SW'(1)) : b_nre;
  assign nim_abs = b_nim[SW-1] ? (~b_nim + SW'(1)) : b_nim;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_re_mag <= nre_abs[PW-1:0];
      c_im_mag <= nim_abs[PW-1:0];
      c_re_neg <= b_nre[SW-1] ^ b_den_neg;
      c_im_neg <= b_nim[SW-1];
      c_den    <= b_den;
      c_ro     <= b_ro;
    end
  end

  // divider lanes
  logic [W-1:0] re_quo, im_quo;
  logic         re_ovf, im_ovf, re_neg, im_neg;

  csd_divider #(.W(W), .F(FRAC_BITS)) u_div_re (
    .clk     (clk),
    .en      (en),
    .num_mag (c_re_mag),
    .den     (c_den),
    .neg     (c_re_neg),
    .quo     (re_quo),
    .ovf     (re_ovf),
    .quo_neg (re_neg)
  );

  csd_divider #(.W(W), .F(FRAC_BITS)) u_div_im (
    .clk     (clk),
    .en      (en),
    .num_mag (c_im_mag),
    .den     (c_den),
    .neg     (c_im_neg),
    .quo     (im_quo),
    .ovf     (im_ovf),
    .quo_neg (im_neg)
  );

  // valid and real-only flags alongside the divider stages
  logic [W:0] div_vld;
  logic [W:0] div_ro;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld <= '0;
    end else if (en) begin
      div_vld <= {div_vld[W-1:0], vc};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_ro <= {div_ro[W-1:0], c_ro};
    end
  end

  // saturation and sign
  logic [W-1:0] re_lim, im_lim, re_mag, im_mag;
  logic         re_sat, im_sat;

  assign re_lim = {1'b0, {(W-1){1'b1}}} + W'(re_neg);
  assign im_lim = {1'b0, {(W-1){1'b1}}} + W'(im_neg);
  assign re_sat = re_ovf || (re_quo > re_lim);
  assign im_sat = im_ovf || (im_quo > im_lim);
  assign re_mag = re_sat ? re_lim : re_quo;
  assign im_mag = im_sat ? im_lim : im_quo;

  // output register
  logic out_ro;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_vld[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re     <= re_neg ? (~re_mag + W'(1)) : re_mag;
      out_im     <= div_ro[W] ? '0 : (im_neg ? (~im_mag + W'(1)) : im_mag);
      range_flag <= re_sat || (!div_ro[W] && im_sat);
      out_ro     <= div_ro[W];
    end
  end

  // real-only items never carry an imaginary part
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ro |-> out_im == '0)
    else $error("real-only item with nonzero imaginary part");

  // a held result freezes every valid bit in the pipeline
  assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(div_vld) && $stable(vc) && $stable(vb) && $stable(va))
    else $error("pipeline moved during stall");

  // an accepted item enters the first stage
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> va)
    else $error("accepted item lost at first stage");

endmodule

[verif/testbench.sv]
module testbench;

  localparam int W = csd_pkg::DATA_WIDTH;
  localparam int FB = csd_pkg::FRAC_BITS;
  localparam int LATENCY = W + 5;
  localparam int N_RANDOM = 1630;

  typedef logic signed [W-1:0] word_t;
  typedef struct packed {
    word_t re;
    word_t im;
    logic  flag;
  } quot_t;
  typedef struct {
    word_t ar;
    word_t ai;
    word_t br;
    word_t bi;
    logic  ro;
    logic  has_exp;
    quot_t exp;
  } row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  cfg_we = 1'b0;
  logic  cfg_data = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  word_t num_re = '0, num_im = '0, den_re = '0, den_im = '0;
  logic  real_only = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  word_t out_re, out_im;
  logic  range_flag;

  logic  conj_q = 1'b0;
  quot_t quot_q[$];
  int    errors = 0;
  int    n_items = 0;
  int    n_results = 0;
  int    n_flagged = 0;

  localparam word_t MAXV = {1'b0, {(W-1){1'b1}}};
  localparam word_t MINV = {1'b1, {(W-1){1'b0}}};
  localparam word_t ONE = word_t'(1) <<< FB;

  complex_spectrum_divide_unit u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50000000;
    $display("complex_spectrum_divide_unit: mismatch");
    $finish;
  end

  // signed quotient of num * 2^FB / den, truncated toward zero, saturated
  function automatic word_t sat_div(logic signed [3*W:0] num, logic signed [3*W:0] den,
                                    inout logic flag);
    logic signed [4*W+FB:0] q;
    logic signed [4*W+FB:0] n;
    n = num;
    n = n <<< FB;
    q = n / den;
    if (q > $signed({1'b0, MAXV})) begin
      flag = 1'b1;
      return MAXV;
    end
    if (q < -$signed({1'b0, MAXV}) - 1) begin
      flag = 1'b1;
      return MINV;
    end
    return word_t'(q);
  endfunction

  function automatic quot_t spectrum_quot(word_t ar, word_t ai, word_t br, word_t bi,
                                          logic ro, logic cj);
    quot_t r;
    logic f;
    logic signed [3*W:0] d, nre, nim;
    f = 1'b0;
    r.im = '0;
    if (ro) begin
      d = br;
      d = d + 1;
      if (d == 0) begin
        f = 1'b1;
        r.re = ar[W-1] ? MINV : MAXV;
      end else begin
        r.re = sat_div(ar, d, f);
      end
    end else begin
      d = br * br + bi * bi + (1 << FB);
      if (cj) begin
        nre = ar * br - ai * bi;
        nim = ai * br + ar * bi;
      end else begin
        nre = ar * br + ai * bi;
        nim = ai * br - ar * bi;
      end
      r.re = sat_div(nre, d, f);
      r.im = sat_div(nim, d, f);
    end
    r.flag = f;
    return r;
  endfunction

  task automatic report(string what, word_t got, word_t want);
    errors++;
    $display("error: %s got %h want %h at result %0d", what, got, want, n_results);
  endtask

  // result side: random stalls, compare against oldest expectation
  initial begin
    int gap;
    quot_t e;
    gap = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (quot_q.size() == 0) begin
          report("unexpected item", out_re, '0);
        end else begin
          e = quot_q.pop_front();
          if (out_re !== e.re) report("out_re", out_re, e.re);
          if (out_im !== e.im) report("out_im", out_im, e.im);
          if (range_flag !== e.flag) report("range_flag", word_t'(range_flag), word_t'(e.flag));
          n_flagged += e.flag;
        end
        n_results++;
        gap = (n_results % 400 < 60) ? 0 : $urandom_range(0, 5);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return MAXV;
      1: return MINV;
      2: return word_t'($urandom_range(0, 4)) - 2;
      3: return word_t'($signed($urandom) >>> $urandom_range(8, 30));
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic send(row_t r);
    quot_t e;
    int gap;
    gap = (n_items % 300 < 40) ? 0 : $urandom_range(0, 5);
    if (gap > 0) in_valid <= 1'b0;
    repeat (gap) @(posedge clk);
    e = spectrum_quot(r.ar, r.ai, r.br, r.bi, r.ro, conj_q);
    if (r.has_exp && e !== r.exp) begin
      report("table row", e.re, r.exp.re);
    end
    in_valid <= 1'b1;
    num_re <= r.ar;
    num_im <= r.ai;
    den_re <= r.br;
    den_im <= r.bi;
    real_only <= r.ro;
    do @(posedge clk); while (!in_ready);
    quot_q = {quot_q, (r.has_exp ? r.exp : e)};
    n_items++;
  endtask

  task automatic drain_idle();
    int t;
    t = 0;
    in_valid <= 1'b0;
    while (quot_q.size() != 0 && t < 200000) begin
      @(posedge clk);
      t++;
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_conj(logic v);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    conj_q = v;
  endtask

  row_t dir_rows[$];

  task automatic add_row(word_t ar, word_t ai, word_t br, word_t bi, logic ro,
                         logic he = 1'b0, word_t ere = '0, word_t eim = '0, logic ef = 1'b0);
    row_t r;
    r.ar = ar; r.ai = ai; r.br = br; r.bi = bi; r.ro = ro; r.has_exp = he;
    r.exp.re = ere; r.exp.im = eim; r.exp.flag = ef;
    dir_rows = {dir_rows, r};
  endtask

  // stimulus
  initial begin
    row_t r;
    int k;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero divisor in real-only mode
    add_row(ONE, MAXV, -1, MINV, 1'b1, 1'b1, MAXV, '0, 1'b1);
    add_row(-ONE, 0, -1, 5, 1'b1, 1'b1, MINV, '0, 1'b1);
    add_row(0, 0, -1, 0, 1'b1, 1'b1, MAXV, '0, 1'b1);
    // zero numerator gives zero
    add_row(0, 0, 0, 0, 1'b0, 1'b1, '0, '0, 1'b0);
    add_row(0, 0, ONE, 0, 1'b1, 1'b1, '0, '0, 1'b0);
    // tiny divisor saturates
    add_row(MAXV, MAXV, 256, 0, 1'b0, 1'b1, MAXV, MAXV, 1'b1);
    add_row(MINV, 0, 0, 0, 1'b1, 1'b1, MINV, '0, 1'b1);
    add_row(ONE, ONE, ONE, ONE, 1'b0);
    add_row(MAXV, MINV, MAXV, MINV, 1'b0);
    add_row(MINV, MINV, MINV, MINV, 1'b0);
    add_row(MAXV, MAXV, MINV, MAXV, 1'b0);
    add_row(MAXV, 0, MAXV, 0, 1'b1);
    add_row(MINV, 0, MINV, 0, 1'b1);
    add_row(MINV, 0, -2, 0, 1'b1);
    add_row(3 * ONE, -ONE, -2 * ONE, ONE / 2, 1'b0);
    add_row(ONE, 0, ONE, 0, 1'b0);
    for (k = 0; k < dir_rows.size(); k++) send(dir_rows[k]);
    write_conj(1'b1);
    for (k = 7; k < dir_rows.size(); k++) begin
      r = dir_rows[k];
      r.has_exp = 1'b0;
      send(r);
    end
    // random phases alternating conjugate mode
    for (k = 0; k < N_RANDOM; k++) begin
      if (k % 400 == 0) write_conj(k % 800 != 0);
      r.ar = rand_word(); r.ai = rand_word(); r.br = rand_word(); r.bi = rand_word();
      r.ro = ($urandom_range(0, 3) == 0);
      r.has_exp = 1'b0;
      send(r);
    end
    drain_idle();
    $display("covered %0d items in both conjugate settings, %0d results, %0d flagged",
             n_items, n_results, n_flagged);
    if (errors == 0 && quot_q.size() == 0) begin
      $display("complex_spectrum_divide_unit: match");
    end else begin
      $display("complex_spectrum_divide_unit: mismatch");
    end
    $finish;
  end
endmodule
